@@ hdl/dbd_pkg.sv @@
// shared types, constants and widths for the detection box decode filter
package dbd_pkg;

    // model geometry and limits
    localparam int MODEL_W     = 480;
    localparam int MODEL_H     = 480;
    localparam int MAX_ROWS    = 8192;
    localparam int NUM_CLASSES = 2;

    // field widths
    localparam int COORD_IN_W = 16;
    localparam int SCORE_W    = 16;
    localparam int CODE_W     = 8;
    localparam int PAD_W      = 9;
    localparam int ISC_W      = 24;
    localparam int INV_W      = 25;
    localparam int CTR_W      = 16;
    localparam int SIZE_W     = 15;
    localparam int TALLY_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // clamp limits in Q11.5
    localparam int X_LIMIT     = MODEL_W * 32;
    localparam int Y_LIMIT     = MODEL_H * 32;
    localparam int COORD_LIMIT = (X_LIMIT > Y_LIMIT) ? X_LIMIT : Y_LIMIT;
    localparam int CW          = $clog2(COORD_LIMIT + 1);
    localparam int CMPW        = (CW > COORD_IN_W - 1) ? CW : COORD_IN_W - 1;

    // edge sum magnitude: c1 + c2 - 64 * pad
    localparam int PAD64_MAX = ((1 << PAD_W) - 1) * 64;
    localparam int SUM_MAX   = (2 * COORD_LIMIT > PAD64_MAX) ? 2 * COORD_LIMIT : PAD64_MAX;
    localparam int SMW       = $clog2(SUM_MAX + 1);
    localparam int SW        = SMW + 1;

    // shared multiplier split
    localparam int M1W  = SMW + ISC_W;
    localparam int HW   = (M1W + 1) / 2;
    localparam int MAW  = (SMW > HW) ? SMW : HW;
    localparam int PRW  = MAW + INV_W;
    localparam int PW   = M1W + INV_W;
    localparam int SUMW = PW + 1;

    // score tally points and cap
    localparam logic [SCORE_W-1:0] SCORE_QUARTER       = 16'd16384;
    localparam logic [SCORE_W-1:0] SCORE_HALF          = 16'd32768;
    localparam logic [SCORE_W-1:0] SCORE_THREE_QUARTER = 16'd49152;
    localparam int TALLY_CAP = (MAX_ROWS < 16383) ? MAX_ROWS : 16383;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT_MODE,
        CFG_CONF_THRESHOLD,
        CFG_PAD_X,
        CFG_PAD_Y,
        CFG_INVERSE_SCALE,
        CFG_INV_SOURCE_WIDTH,
        CFG_INV_SOURCE_HEIGHT
    } t_cfg_reg;

    typedef enum logic {
        FMT_ANCHOR,
        FMT_POST_NMS
    } t_format;

    // register reset values
    localparam logic [SCORE_W-1:0] CONF_THRESHOLD_RST = 16'd32768;
    localparam logic [ISC_W-1:0]   INVERSE_SCALE_RST  = 24'd65536;
    localparam logic [INV_W-1:0]   INV_SOURCE_RST     = 25'd34953;

    typedef struct packed {
        logic                    format_mode;
        logic [SCORE_W-1:0]      conf_threshold;
        logic [PAD_W-1:0]        pad_x;
        logic [PAD_W-1:0]        pad_y;
        logic [ISC_W-1:0]        inverse_scale;
        logic [INV_W-1:0]        inv_source_width;
        logic [INV_W-1:0]        inv_source_height;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_IN_W-1:0] left_edge;
        logic signed [COORD_IN_W-1:0] top_edge;
        logic signed [COORD_IN_W-1:0] right_edge;
        logic signed [COORD_IN_W-1:0] bottom_edge;
        logic [SCORE_W-1:0]           score_a;
        logic [SCORE_W-1:0]           score_b;
        logic signed [CODE_W-1:0]     class_code;
        logic                         frame_end;
    } t_in_item;

    typedef struct packed {
        logic                      keep;
        logic signed [CTR_W-1:0]   centre_x;
        logic signed [CTR_W-1:0]   centre_y;
        logic [SIZE_W-1:0]         box_width;
        logic [SIZE_W-1:0]         box_height;
        logic [SCORE_W-1:0]        score;
        logic                      class_out;
        logic [SCORE_W-1:0]        max_score;
        logic [TALLY_W-1:0]        count_quarter;
        logic [TALLY_W-1:0]        count_half;
        logic [TALLY_W-1:0]        count_three_quarter;
        logic                      frame_done;
    } t_out_item;

    typedef struct packed {
        logic           neg;
        logic [SMW-1:0] mag;
    } t_sgnmag;

    // one classified row waiting for the back end
    typedef struct packed {
        logic                keep;
        t_sgnmag             sum_x;
        t_sgnmag             sum_y;
        logic [SMW-1:0]      diff_x;
        logic [SMW-1:0]      diff_y;
        logic [SCORE_W-1:0]  score;
        logic                class_out;
        logic [SCORE_W-1:0]  max_score;
        logic [TALLY_W-1:0]  count_quarter;
        logic [TALLY_W-1:0]  count_half;
        logic [TALLY_W-1:0]  count_three_quarter;
        logic                frame_done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ hdl/dbd_ifs.sv @@
// channel interfaces: input rows, result rows, register writes
interface dbd_in_if import dbd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbd_out_if import dbd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbd_cfg_if import dbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/dbd_front.sv @@
// front end: class choice, frame statistics, clamp and keep decision
module dbd_front import dbd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dbd_in_if.sink       i_in,
    input  t_cfg         i_regs,
    input  t_q_stat      i_qstat,
    output logic         o_push,
    output t_job         o_job
);

    logic [SCORE_W-1:0] r_max;
    logic [TALLY_W-1:0] r_tq;
    logic [TALLY_W-1:0] r_th;
    logic [TALLY_W-1:0] r_tt;

    logic [SCORE_W-1:0] n_max;
    logic [TALLY_W-1:0] n_tq;
    logic [TALLY_W-1:0] n_th;
    logic [TALLY_W-1:0] n_tt;

    logic [SCORE_W-1:0] score;
    logic               cls;
    logic               code_ok;
    logic [CW-1:0]      cx1, cy1, cx2, cy2;
    logic [CW:0]        dx, dy;
    logic               dx_pos, dy_pos;

    function automatic logic [CW-1:0] clamp_coord(logic signed [COORD_IN_W-1:0] raw,
                                                  logic [CMPW-1:0] lim);
        logic [CMPW-1:0] mag;
        mag = CMPW'(raw[COORD_IN_W-2:0]);
        if (raw[COORD_IN_W-1]) begin
            return '0;
        end else if (mag > lim) begin
            return CW'(lim);
        end
        return CW'(mag);
    endfunction

    function automatic t_sgnmag edge_sum(logic [CW-1:0] c1, logic [CW-1:0] c2,
                                         logic [PAD_W-1:0] pad);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] s_neg;
        t_sgnmag              r;
        s       = SW'(c1) + SW'(c2) - SW'({pad, 6'b0});
        s_neg   = -s;
        r.neg   = s[SW-1];
        r.mag   = s[SW-1] ? s_neg[SMW-1:0] : s[SMW-1:0];
        return r;
    endfunction

    function automatic logic [TALLY_W-1:0] tally_up(logic [TALLY_W-1:0] t);
        return (t < TALLY_W'(TALLY_CAP)) ? t + 1'b1 : TALLY_W'(TALLY_CAP);
    endfunction

    assign i_in.ready = i_rst_n && !i_qstat.full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        if (i_regs.format_mode == FMT_ANCHOR) begin
            code_ok = 1'b0;
            if (i_in.data.score_a > i_in.data.score_b) begin
                score = i_in.data.score_a;
                cls   = 1'b0;
            end else begin
                score = i_in.data.score_b;
                cls   = 1'b1;
            end
        end else begin
            // negative or too large class code falls back to class 0
            code_ok = !i_in.data.class_code[CODE_W-1]
                      && (i_in.data.class_code[CODE_W-2:0] < (CODE_W-1)'(NUM_CLASSES));
            score   = i_in.data.score_a;
            cls     = code_ok ? i_in.data.class_code[0] : 1'b0;
        end

        n_max = (score > r_max) ? score : r_max;
        n_tq  = (score >= SCORE_QUARTER)       ? tally_up(r_tq) : r_tq;
        n_th  = (score >= SCORE_HALF)          ? tally_up(r_th) : r_th;
        n_tt  = (score >= SCORE_THREE_QUARTER) ? tally_up(r_tt) : r_tt;

        cx1 = clamp_coord(i_in.data.left_edge,   CMPW'(X_LIMIT));
        cy1 = clamp_coord(i_in.data.top_edge,    CMPW'(Y_LIMIT));
        cx2 = clamp_coord(i_in.data.right_edge,  CMPW'(X_LIMIT));
        cy2 = clamp_coord(i_in.data.bottom_edge, CMPW'(Y_LIMIT));

        // padding cancels in the differences
        dx     = (CW+1)'(cx2) - (CW+1)'(cx1);
        dy     = (CW+1)'(cy2) - (CW+1)'(cy1);
        dx_pos = !dx[CW] && (dx != '0);
        dy_pos = !dy[CW] && (dy != '0);

        o_job.keep                = (score >= i_regs.conf_threshold) && dx_pos && dy_pos
                                    && (i_regs.inverse_scale != '0);
        o_job.sum_x               = edge_sum(cx1, cx2, i_regs.pad_x);
        o_job.sum_y               = edge_sum(cy1, cy2, i_regs.pad_y);
        o_job.diff_x              = SMW'(dx[CW-1:0]);
        o_job.diff_y              = SMW'(dy[CW-1:0]);
        o_job.score               = score;
        o_job.class_out           = cls;
        o_job.max_score           = n_max;
        o_job.count_quarter       = n_tq;
        o_job.count_half          = n_th;
        o_job.count_three_quarter = n_tt;
        o_job.frame_done          = i_in.data.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_tq  <= '0;
            r_th  <= '0;
            r_tt  <= '0;
        end else if (o_push) begin
            if (i_in.data.frame_end) begin
                r_max <= '0;
                r_tq  <= '0;
                r_th  <= '0;
                r_tt  <= '0;
            end else begin
                r_max <= n_max;
                r_tq  <= n_tq;
                r_th  <= n_th;
                r_tt  <= n_tt;
            end
        end
    end

endmodule

@@ hdl/dbd_queue.sv @@
// short queue of classified rows between front and back end
module dbd_queue import dbd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job            r_mem [QUEUE_DEPTH];
    logic [QPW-1:0]  r_wr;
    logic [QPW-1:0]  r_rd;
    logic [QCW-1:0]  r_count;

    function automatic logic [QPW-1:0] ptr_next(logic [QPW-1:0] p);
        return (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue read while empty");

endmodule

@@ hdl/dbd_back.sv @@
// back end: un-letterbox and normalize kept rows on one shared multiplier
module dbd_back import dbd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_regs,
    input  t_q_stat  i_qstat,
    input  t_job     i_job,
    output logic     o_pop,
    dbd_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_LO,
        S_HI,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        Q_CX,
        Q_CY,
        Q_BW,
        Q_BH
    } t_qty;

    localparam int CTR_SHIFT = 32;
    localparam int WID_SHIFT = 31;
    localparam int RCW       = SUMW - CTR_SHIFT;
    localparam int RWW       = SUMW - WID_SHIFT;
    localparam logic [SUMW-1:0] RND_CTR = {{(SUMW-CTR_SHIFT){1'b0}}, 1'b1, 31'd0};
    localparam logic [SUMW-1:0] RND_WID = {{(SUMW-WID_SHIFT){1'b0}}, 1'b1, 30'd0};

    t_state              r_state;
    t_qty                r_q;
    t_job                r_job;
    logic [M1W-1:0]      r_m;
    logic [PRW-1:0]      r_prod;
    logic [SUMW-1:0]     r_acc;
    logic [CTR_W-1:0]    r_cx, r_cy;
    logic [SIZE_W-1:0]   r_bw, r_bh;
    logic                r_ov;
    t_out_item           r_out;

    logic [SMW-1:0]      mag;
    logic                neg;
    logic                centre;
    logic [INV_W-1:0]    inv;
    logic [MAW-1:0]      mul_a;
    logic [INV_W-1:0]    mul_b;
    logic [PRW-1:0]      prod;
    logic [SUMW-1:0]     sum;
    logic [RCW-1:0]      rc;
    logic [RWW-1:0]      rw;
    logic [CTR_W-1:0]    ctr_val;
    logic [SIZE_W-1:0]   wid_val;
    logic                out_free;
    logic                out_load;

    function automatic t_out_item make_out(t_job j, logic k, logic [CTR_W-1:0] cx,
                                           logic [CTR_W-1:0] cy, logic [SIZE_W-1:0] bw,
                                           logic [SIZE_W-1:0] bh);
        t_out_item o;
        o.keep                = k;
        o.centre_x            = cx;
        o.centre_y            = cy;
        o.box_width           = bw;
        o.box_height          = bh;
        o.score               = j.score;
        o.class_out           = j.class_out;
        o.max_score           = j.max_score;
        o.count_quarter       = j.count_quarter;
        o.count_half          = j.count_half;
        o.count_three_quarter = j.count_three_quarter;
        o.frame_done          = j.frame_done;
        return o;
    endfunction

    assign out_free    = !r_ov || o_out.ready;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
    assign o_pop       = (r_state == S_IDLE) && !i_qstat.empty && (i_job.keep || out_free);
    // output register takes a dropped row from the queue or a finished kept row
    assign out_load    = out_free
                         && (((r_state == S_IDLE) && !i_qstat.empty && !i_job.keep)
                             || (r_state == S_DONE));

    always_comb begin
        unique case (r_q)
            Q_CX: begin
                mag    = r_job.sum_x.mag;
                neg    = r_job.sum_x.neg;
                centre = 1'b1;
                inv    = i_regs.inv_source_width;
            end
            Q_CY: begin
                mag    = r_job.sum_y.mag;
                neg    = r_job.sum_y.neg;
                centre = 1'b1;
                inv    = i_regs.inv_source_height;
            end
            Q_BW: begin
                mag    = r_job.diff_x;
                neg    = 1'b0;
                centre = 1'b0;
                inv    = i_regs.inv_source_width;
            end
            Q_BH: begin
                mag    = r_job.diff_y;
                neg    = 1'b0;
                centre = 1'b0;
                inv    = i_regs.inv_source_height;
            end
            default: begin
                mag    = '0;
                neg    = 1'b0;
                centre = 1'b0;
                inv    = '0;
            end
        endcase

        // magnitude times scale, then that product in two halves times the reciprocal
        unique case (r_state)
            S_MUL1: begin
                mul_a = MAW'(mag);
                mul_b = INV_W'(i_regs.inverse_scale);
            end
            S_LO: begin
                mul_a = MAW'(r_m[HW-1:0]);
                mul_b = inv;
            end
            S_HI: begin
                mul_a = MAW'(r_m[M1W-1:HW]);
                mul_b = inv;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;

        sum = r_acc + (SUMW'(r_prod) << HW);
        rc  = sum[SUMW-1:CTR_SHIFT];
        rw  = sum[SUMW-1:WID_SHIFT];

        if (neg) begin
            ctr_val = (rc > RCW'(32768)) ? 16'h8000 : ~rc[CTR_W-1:0] + 1'b1;
        end else begin
            ctr_val = (rc > RCW'(32767)) ? 16'h7fff : rc[CTR_W-1:0];
        end
        wid_val = (rw > RWW'(32767)) ? 15'h7fff : rw[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q     <= Q_CX;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= out_load || (r_ov && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        if (i_job.keep) begin
                            r_job   <= i_job;
                            r_q     <= Q_CX;
                            r_state <= S_MUL1;
                        end else if (out_free) begin
                            r_out <= make_out(i_job, 1'b0, '0, '0, '0, '0);
                        end
                    end
                end
                S_MUL1: begin
                    r_m     <= prod[M1W-1:0];
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_prod  <= prod;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_acc   <= SUMW'(r_prod) + (centre ? RND_CTR : RND_WID);
                    r_prod  <= prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    unique case (r_q)
                        Q_CX: begin
                            r_cx    <= ctr_val;
                            r_q     <= Q_CY;
                            r_state <= S_MUL1;
                        end
                        Q_CY: begin
                            r_cy    <= ctr_val;
                            r_q     <= Q_BW;
                            r_state <= S_MUL1;
                        end
                        Q_BW: begin
                            r_bw    <= wid_val;
                            r_q     <= Q_BH;
                            r_state <= S_MUL1;
                        end
                        Q_BH: begin
                            r_bh    <= wid_val;
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= make_out(r_job, 1'b1, r_cx, r_cy, r_bw, r_bh);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_math_only_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> r_job.keep)
        else $error("box arithmetic started on a dropped row");

    a_dropped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.keep) |->
            (o_out.data.centre_x == '0 && o_out.data.centre_y == '0
             && o_out.data.box_width == '0 && o_out.data.box_height == '0))
        else $error("dropped row carries box geometry");

endmodule

@@ hdl/detection_box_decode_filter.sv @@
// top level of the detection box decode filter: registers, front, queue, back
//
//   channel   dir  handshake      payload
//   i_in      in   valid / ready  t_in_item, one detector row
//   o_out     out  valid / ready  t_out_item, one result row
//   i_cfg     in   valid / ready  register index and write data
//
// a dropped row (below threshold, empty box or zero inverse scale) skips the
// multiplier, so such rows stream at one per cycle while the sink takes results
// and the back end is idle; a kept row holds the back end while the single 20x25
// multiplier runs three products and one round/saturate step for each of the four box values
// reset is synchronous and active low: statistics clear, registers load defaults
// a two-entry queue lets the front keep taking rows while the back end works,
// and the output register holds a result while the sink stalls
module detection_box_decode_filter import dbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbd_in_if.sink    i_in,
    dbd_out_if.source o_out,
    dbd_cfg_if.sink   i_cfg
);

    t_cfg    r_regs;
    t_job    push_job;
    t_job    head_job;
    t_q_stat qstat;
    logic    push;
    logic    pop;

    // register writes are taken every cycle outside reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.format_mode       <= FMT_ANCHOR;
            r_regs.conf_threshold    <= CONF_THRESHOLD_RST;
            r_regs.pad_x             <= '0;
            r_regs.pad_y             <= '0;
            r_regs.inverse_scale     <= INVERSE_SCALE_RST;
            r_regs.inv_source_width  <= INV_SOURCE_RST;
            r_regs.inv_source_height <= INV_SOURCE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_FORMAT_MODE:       r_regs.format_mode       <= i_cfg.data[0];
                CFG_CONF_THRESHOLD:    r_regs.conf_threshold    <= i_cfg.data[SCORE_W-1:0];
                CFG_PAD_X:             r_regs.pad_x             <= i_cfg.data[PAD_W-1:0];
                CFG_PAD_Y:             r_regs.pad_y             <= i_cfg.data[PAD_W-1:0];
                CFG_INVERSE_SCALE:     r_regs.inverse_scale     <= i_cfg.data[ISC_W-1:0];
                CFG_INV_SOURCE_WIDTH:  r_regs.inv_source_width  <= i_cfg.data[INV_W-1:0];
                CFG_INV_SOURCE_HEIGHT: r_regs.inv_source_height <= i_cfg.data[INV_W-1:0];
                // unused index, write ignored
                default: ;
            endcase
        end
    end

    // classify the row, update frame statistics, clamp the corners
    dbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_regs  (r_regs),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (push_job)
    );

    // decouples row intake from the multiply sequence
    dbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    // un-letterbox, normalize, round and saturate, then present the transfer
    dbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_regs  (r_regs),
        .i_qstat (qstat),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ bench/detection_box_decode_filter_tb.sv @@
// self-checking bench for the detection box decode filter: predicts every result row and compares
`timescale 1ns / 1ps

module detection_box_decode_filter_tb import dbd_pkg::*; ();

    // quiet cycles before the run is declared hung
    localparam int STALL_LIMIT   = 3000;
    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES   = 300;
    // allowance for a kept row to finish in the back end, plus queue and output stage
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS   = 40;
    localparam int RANDOM_ROWS   = 50;
    localparam int TALLY_ROWS    = 40;

    // ------------------------------------------------------------------
    // predictor and store of expected result rows
    // ------------------------------------------------------------------
    class box_scoreboard;
        t_cfg               regs;
        logic [SCORE_W-1:0] run_max;
        logic [TALLY_W-1:0] tally_q;
        logic [TALLY_W-1:0] tally_h;
        logic [TALLY_W-1:0] tally_tq;
        t_out_item          due_rows[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        kept;
        int unsigned        frames;

        function new();
            regs.format_mode       = FMT_ANCHOR;
            regs.conf_threshold    = CONF_THRESHOLD_RST;
            regs.pad_x             = '0;
            regs.pad_y             = '0;
            regs.inverse_scale     = INVERSE_SCALE_RST;
            regs.inv_source_width  = INV_SOURCE_RST;
            regs.inv_source_height = INV_SOURCE_RST;
            run_max    = '0;
            tally_q    = '0;
            tally_h    = '0;
            tally_tq   = '0;
            mismatches = 0;
            checked    = 0;
            kept       = 0;
            frames     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (t_cfg_reg'(idx))
                CFG_FORMAT_MODE:       regs.format_mode       = val[0];
                CFG_CONF_THRESHOLD:    regs.conf_threshold    = val[SCORE_W-1:0];
                CFG_PAD_X:             regs.pad_x             = val[PAD_W-1:0];
                CFG_PAD_Y:             regs.pad_y             = val[PAD_W-1:0];
                CFG_INVERSE_SCALE:     regs.inverse_scale     = val[ISC_W-1:0];
                CFG_INV_SOURCE_WIDTH:  regs.inv_source_width  = val[INV_W-1:0];
                CFG_INV_SOURCE_HEIGHT: regs.inv_source_height = val[INV_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TALLY_W-1:0] bump(logic [TALLY_W-1:0] t);
            return (t < TALLY_CAP) ? t + 1'b1 : TALLY_CAP[TALLY_W-1:0];
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // clamp to the model, take off padding, scale to source pixels (Q.21)
        function longint scale_edge(logic signed [COORD_IN_W-1:0] raw, int lim,
                                    logic [PAD_W-1:0] pad);
            longint c;
            c = raw;
            c = clip(c, 0, longint'(lim));
            return (c - 32 * longint'(pad)) * longint'(regs.inverse_scale);
        endfunction

        // round(|v| * k / 2^sh) half up, sign put back afterwards
        function longint round_mul(longint v, logic [INV_W-1:0] k, int sh);
            logic [127:0] mag;
            logic [127:0] acc;
            longint       r;
            mag = (v < 0) ? -v : v;
            acc = (mag * k + (128'd1 << (sh - 1))) >> sh;
            r = longint'(acc[62:0]);
            return (v < 0) ? -r : r;
        endfunction

        function t_out_item decode_row(t_in_item row);
            t_out_item          res;
            logic [SCORE_W-1:0] sc;
            logic               cls;
            int                 code;
            longint             x1, y1, x2, y2, pw, ph;
            res = '0;
            if (t_format'(regs.format_mode) == FMT_ANCHOR) begin
                // ties go to class 1
                if (row.score_a > row.score_b) begin
                    sc  = row.score_a;
                    cls = 1'b0;
                end else begin
                    sc  = row.score_b;
                    cls = 1'b1;
                end
            end else begin
                code = row.class_code;
                sc   = row.score_a;
                cls  = (code >= 0 && code < NUM_CLASSES) ? code[0] : 1'b0;
            end
            if (sc > run_max) run_max = sc;
            if (sc >= SCORE_QUARTER) tally_q = bump(tally_q);
            if (sc >= SCORE_HALF) tally_h = bump(tally_h);
            if (sc >= SCORE_THREE_QUARTER) tally_tq = bump(tally_tq);
            if (sc >= regs.conf_threshold) begin
                x1 = scale_edge(row.left_edge, X_LIMIT, regs.pad_x);
                y1 = scale_edge(row.top_edge, Y_LIMIT, regs.pad_y);
                x2 = scale_edge(row.right_edge, X_LIMIT, regs.pad_x);
                y2 = scale_edge(row.bottom_edge, Y_LIMIT, regs.pad_y);
                pw = x2 - x1;
                ph = y2 - y1;
                if (pw > 0 && ph > 0) begin
                    res.keep       = 1'b1;
                    res.centre_x   = CTR_W'(clip(round_mul(x1 + x2, regs.inv_source_width, 32),
                                                 -32768, 32767));
                    res.centre_y   = CTR_W'(clip(round_mul(y1 + y2, regs.inv_source_height, 32),
                                                 -32768, 32767));
                    res.box_width  = SIZE_W'(clip(round_mul(pw, regs.inv_source_width, 31),
                                                  0, 32767));
                    res.box_height = SIZE_W'(clip(round_mul(ph, regs.inv_source_height, 31),
                                                  0, 32767));
                end
            end
            res.score               = sc;
            res.class_out           = cls;
            res.max_score           = run_max;
            res.count_quarter       = tally_q;
            res.count_half          = tally_h;
            res.count_three_quarter = tally_tq;
            res.frame_done          = row.frame_end;
            if (row.frame_end) begin
                run_max  = '0;
                tally_q  = '0;
                tally_h  = '0;
                tally_tq = '0;
            end
            return res;
        endfunction

        function void note_row(t_in_item row);
            due_rows = {due_rows, decode_row(row)};
        endfunction

        function void field(string name, logic signed [63:0] want, logic signed [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t ns row %0d %s: expected %0d, actual %0d",
                             $time, checked, name, want, got);
            end
        endfunction

        function void check_row(t_out_item got);
            t_out_item want;
            if (due_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t ns result with nothing expected: expected none, actual %h",
                             $time, got);
                return;
            end
            want = due_rows.pop_front();
            field("keep", want.keep, got.keep);
            field("centre_x", want.centre_x, got.centre_x);
            field("centre_y", want.centre_y, got.centre_y);
            field("box_width", want.box_width, got.box_width);
            field("box_height", want.box_height, got.box_height);
            field("score", want.score, got.score);
            field("class_out", want.class_out, got.class_out);
            field("max_score", want.max_score, got.max_score);
            field("count_quarter", want.count_quarter, got.count_quarter);
            field("count_half", want.count_half, got.count_half);
            field("count_three_quarter", want.count_three_quarter, got.count_three_quarter);
            field("frame_done", want.frame_done, got.frame_done);
            checked++;
            if (want.keep) kept++;
            if (want.frame_done) frames++;
        endfunction

        function int due_count();
            return due_rows.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    dbd_in_if  in_ch ();
    dbd_out_if out_ch ();
    dbd_cfg_if cfg_ch ();

    detection_box_decode_filter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    box_scoreboard book = new();

    // idle odds in percent for each side, changed per epoch
    int unsigned snd_idle_pct = 26;
    int unsigned rcv_idle_pct = 66;
    // long receiver hold-off, owned by its own process
    bit          rcv_hold     = 1'b0;
    int unsigned settings_used = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // everything driven from time zero
    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
    end

    // receiver: random back-pressure, forced low during a hold-off
    always @(negedge i_clk) begin
        out_ch.ready = !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
    end

    // monitor: register writes, accepted rows and results, in that order per edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) book.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready) book.note_row(in_ch.data);
            if (out_ch.valid && out_ch.ready) book.check_row(out_ch.data);
        end
    end

    // watchdog: any transfer on any channel restarts the count
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
                (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one row, with random gaps ahead of it; valid stays high on return
    task automatic send_row(input t_in_item row);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = row;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_regs(input t_format fmt, input logic [SCORE_W-1:0] thr,
                            input logic [PAD_W-1:0] px, input logic [PAD_W-1:0] py,
                            input logic [ISC_W-1:0] isc, input logic [INV_W-1:0] iw,
                            input logic [INV_W-1:0] ih);
        write_reg(CFG_FORMAT_MODE, CFG_DATA_W'(fmt));
        write_reg(CFG_CONF_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_PAD_X, CFG_DATA_W'(px));
        write_reg(CFG_PAD_Y, CFG_DATA_W'(py));
        write_reg(CFG_INVERSE_SCALE, CFG_DATA_W'(isc));
        write_reg(CFG_INV_SOURCE_WIDTH, iw);
        write_reg(CFG_INV_SOURCE_HEIGHT, ih);
        settings_used++;
    endtask

    // drop valid, wait for every expected row, then let the back end go quiet
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (book.due_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(int l, int t, int r, int b, int sa, int sb, int cc, bit fe);
        t_in_item row;
        row.left_edge   = l[15:0];
        row.top_edge    = t[15:0];
        row.right_edge  = r[15:0];
        row.bottom_edge = b[15:0];
        row.score_a     = sa[15:0];
        row.score_b     = sb[15:0];
        row.class_code  = cc[7:0];
        row.frame_end   = fe;
        return row;
    endfunction

    // half the scores land close to the threshold so both sides of it are hit
    function automatic logic [SCORE_W-1:0] pick_score(logic [SCORE_W-1:0] thr);
        int s;
        if ($urandom_range(1)) begin
            s = int'(thr) + int'($urandom_range(0, 4096)) - 2048;
            if (s < 0) s = 0;
            if (s > 65535) s = 65535;
            return s[15:0];
        end
        return SCORE_W'($urandom);
    endfunction

    // mostly plausible boxes inside the model, some spilling over, some pure noise
    function automatic t_in_item random_row(logic [SCORE_W-1:0] thr);
        t_in_item row;
        int       x_lo, x_hi, y_lo, y_hi, s;
        if ($urandom_range(99) < 15) begin
            row.left_edge   = COORD_IN_W'($urandom);
            row.top_edge    = COORD_IN_W'($urandom);
            row.right_edge  = COORD_IN_W'($urandom);
            row.bottom_edge = COORD_IN_W'($urandom);
            row.score_a     = SCORE_W'($urandom);
            row.score_b     = SCORE_W'($urandom);
            row.class_code  = CODE_W'($urandom);
            row.frame_end   = ($urandom_range(7) == 0);
            return row;
        end
        x_lo = $urandom_range(0, X_LIMIT);
        x_hi = $urandom_range(0, X_LIMIT);
        y_lo = $urandom_range(0, Y_LIMIT);
        y_hi = $urandom_range(0, Y_LIMIT);
        if (x_lo > x_hi) begin
            s = x_lo; x_lo = x_hi; x_hi = s;
        end
        if (y_lo > y_hi) begin
            s = y_lo; y_lo = y_hi; y_hi = s;
        end
        if ($urandom_range(9) == 0) x_lo -= $urandom_range(0, 4000);
        if ($urandom_range(9) == 0) x_hi += $urandom_range(0, 4000);
        if ($urandom_range(9) == 0) y_lo -= $urandom_range(0, 4000);
        if ($urandom_range(9) == 0) y_hi += $urandom_range(0, 4000);
        row.left_edge   = x_lo[15:0];
        row.top_edge    = y_lo[15:0];
        row.right_edge  = x_hi[15:0];
        row.bottom_edge = y_hi[15:0];
        row.score_a     = pick_score(thr);
        row.score_b     = pick_score(thr);
        if ($urandom_range(15) == 0) row.score_b = row.score_a;
        row.class_code  = ($urandom_range(3) == 0) ? CODE_W'($urandom)
                                                   : CODE_W'($urandom_range(0, 1));
        row.frame_end   = ($urandom_range(15) == 0);
        return row;
    endfunction

    task automatic apply_setting(input int n);
        case (n)
            // 640x480 source letterboxed into the model
            0: begin
                set_regs(FMT_ANCHOR, 16'd32768, 9'd0, 9'd60, 24'd87381, 25'd26214, 25'd34953);
            end
            1: begin
                set_regs(FMT_POST_NMS, 16'd16384, 9'd0, 9'd0, 24'd65536, 25'd34953, 25'd34953);
            end
            // everything at the top end: every row scored, outputs saturate
            2: begin
                set_regs(FMT_ANCHOR, 16'd0, 9'd480, 9'd480, 24'hFFFFFF, 25'h1000000,
                         25'h1000000);
            end
            3: begin
                set_regs(FMT_POST_NMS, 16'hFFFF, 9'd480, 9'd0, ISC_W'($urandom),
                         INV_W'($urandom_range(0, 1 << 24)),
                         INV_W'($urandom_range(0, 1 << 24)));
            end
            // tiny scale and zero reciprocals: kept rows with all-zero geometry
            5: begin
                set_regs(FMT_POST_NMS, 16'd8000, 9'd240, 9'd0, 24'd1, 25'd0, 25'd0);
            end
            default: begin
                set_regs(t_format'($urandom_range(1)), SCORE_W'($urandom),
                         PAD_W'($urandom_range(0, 480)), PAD_W'($urandom_range(0, 480)),
                         ISC_W'($urandom), INV_W'($urandom_range(0, 1 << 24)),
                         INV_W'($urandom_range(0, 1 << 24)));
            end
        endcase
    endtask

    task automatic random_phase(input int n);
        repeat (n) send_row(random_row(book.regs.conf_threshold));
        settle();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        t_in_item row;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // epoch 0: sender idles now and then, receiver most of the time
        snd_idle_pct = 26;
        rcv_idle_pct = 66;

        // reset settings, anchor rows: class choice and keep rules
        send_row(mk(320, 320, 3200, 3200, 40000, 1000, 0, 0));       // class 0 wins
        send_row(mk(0, 0, X_LIMIT, Y_LIMIT, 50000, 50000, 0, 0));    // tie goes to class 1
        send_row(mk(100, 200, 300, 400, 0, 65535, 0, 0));            // top score, class 1
        send_row(mk(1000, 1000, 2000, 2000, 32768, 0, 0, 0));        // exactly at threshold
        send_row(mk(1000, 1000, 2000, 2000, 32767, 0, 0, 0));        // one below threshold
        send_row(mk(-32768, -32768, 32767, 32767, 65535, 0, 0, 0));  // corners clamp to model
        send_row(mk(32767, 100, -32768, 900, 60000, 0, 0, 0));       // inverted box
        send_row(mk(5000, 100, 5000, 900, 60000, 0, 0, 0));          // zero width
        send_row(mk(100, 7000, 900, 7000, 60000, 0, 0, 0));          // zero height
        send_row(mk(-500, 100, -10, 900, 60000, 0, 0, 0));           // both x left of model
        send_row(mk(100, 100, 900, 900, 0, 0, 0, 1));                // zero scores, frame end
        send_row(mk(100, 100, 900, 900, 16384, 16383, 0, 0));        // quarter boundary
        send_row(mk(100, 100, 900, 900, 49152, 49151, 0, 1));        // three-quarter, frame end
        settle();

        // post-NMS class codes, in range and out of range on both sides
        write_reg(CFG_FORMAT_MODE, CFG_DATA_W'(FMT_POST_NMS));
        send_row(mk(320, 320, 6400, 6400, 60000, 12345, -128, 0));
        send_row(mk(320, 320, 6400, 6400, 60000, 65535, -1, 0));
        send_row(mk(320, 320, 6400, 6400, 60000, 0, 0, 0));
        send_row(mk(320, 320, 6400, 6400, 60000, 0, 1, 0));
        send_row(mk(320, 320, 6400, 6400, 60000, 0, 2, 0));
        send_row(mk(320, 320, 6400, 6400, 60000, 0, 127, 1));
        settle();

        // full padding, full scale: negative centres and saturated sizes
        set_regs(FMT_POST_NMS, 16'd0, 9'd480, 9'd480, 24'hFFFFFF, 25'h1000000, 25'h1000000);
        send_row(mk(0, 0, X_LIMIT, Y_LIMIT, 0, 0, 1, 0));
        send_row(mk(15000, 15000, X_LIMIT, Y_LIMIT, 1, 0, 0, 0));
        settle();

        // zero scale collapses every box
        write_reg(CFG_INVERSE_SCALE, '0);
        send_row(mk(0, 0, X_LIMIT, Y_LIMIT, 65535, 0, 0, 1));
        settle();

        apply_setting(0);
        random_phase(RANDOM_ROWS);
        apply_setting(1);
        random_phase(RANDOM_ROWS);
        apply_setting(2);
        random_phase(RANDOM_ROWS);

        // epoch 1: the two sides swap roles
        snd_idle_pct = 66;
        rcv_idle_pct = 26;
        apply_setting(3);
        random_phase(RANDOM_ROWS);
        apply_setting(4);
        random_phase(RANDOM_ROWS);

        // epoch 2: full rate on both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        apply_setting(5);
        random_phase(RANDOM_ROWS);
        apply_setting(6);
        random_phase(RANDOM_ROWS);

        // receiver stalls long enough for the queue and output stage to fill
        apply_setting(1);
        fork
            begin
                rcv_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rcv_hold = 1'b0;
            end
            begin
                repeat (40) send_row(random_row(book.regs.conf_threshold));
            end
        join
        settle();

        // one frame of high scores under an unreachable threshold: all three tallies climb
        set_regs(FMT_ANCHOR, 16'hFFFF, 9'd0, 9'd0, 24'd65536, 25'd34953, 25'd34953);
        for (int i = 0; i < TALLY_ROWS; i++) begin
            row = random_row(16'hFFFF);
            row.score_a   = SCORE_W'($urandom_range(49152, 65534));
            row.score_b   = SCORE_W'($urandom_range(0, 49151));
            row.frame_end = (i == TALLY_ROWS - 1);
            send_row(row);
        end
        settle();

        if (book.due_count() != 0)
            $display("%0t ns %0d expected rows never arrived", $time, book.due_count());
        $display("checked %0d result rows (%0d kept, %0d frames) over %0d register settings",
                 book.checked, book.kept, book.frames, settings_used);
        $display("both idle patterns, a %0d-cycle receiver hold-off and a high-score frame covered",
                 HOLD_CYCLES);
        if (book.mismatches == 0 && book.due_count() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
